// File: hw/rtl/psed_pkg.sv
package psed_pkg;

	localparam int TABLE_ENTRIES  = 16;
	localparam int SSID_MAX_BYTES = 32;

	localparam int SLOT_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int COUNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam int SUM_W   = COUNT_W + 1;
	localparam int OFF_W   = $clog2(SSID_MAX_BYTES);
	localparam int LEN_W   = OFF_W + 1;
	localparam int POS_W   = 5;

	localparam logic [7:0] PROBE_SUBTYPE = 8'h40;
	localparam logic [7:0] PRINT_LOW     = 8'd32;
	localparam logic [7:0] PRINT_HIGH    = 8'd126;
	localparam logic [POS_W-1:0] TAG_START     = POS_W'(24);
	localparam logic [POS_W-1:0] MIN_LAST_POS  = POS_W'(25);

	typedef enum logic [2:0] {
		OC_IGNORED   = 3'd0,
		OC_NO_SSID   = 3'd1,
		OC_BAD_LEN   = 3'd2,
		OC_UNPRINT   = 3'd3,
		OC_DUPLICATE = 3'd4,
		OC_NEW       = 3'd5
	} outcome_t;

	typedef enum logic {
		OP_FRAME = 1'b0,
		OP_READ  = 1'b1
	} opcode_t;

	typedef enum logic [2:0] {
		PS_NUM, PS_LEN, PS_SKIP, PS_COLLECT, PS_DONE
	} parse_state_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_RD, ST_META, ST_LEN, ST_CMP, ST_HIT, ST_INS, ST_COPY, ST_OUT
	} state_t;

	typedef struct packed {
		logic        opcode;
		logic [7:0]  data_byte;
		logic        frame_last;
		logic        frame_is_mgmt;
		logic [31:0] time_stamp;
		logic [3:0]  read_slot;
		logic [4:0]  read_offset;
	} req_word_t;

	typedef struct packed {
		logic [2:0]  outcome;
		logic [3:0]  entry_slot;
		logic [31:0] entry_hits;
		logic [31:0] probe_total;
		logic [31:0] unique_total;
		logic [4:0]  table_count;
		logic [7:0]  read_byte;
		logic [5:0]  read_length;
		logic [31:0] read_time;
	} rsp_word_t;

	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic [31:0]      stamp;
		logic [31:0]      hits;
	} meta_t;

	// physical slot of the entry 'off' places after 'base', wrapping round the ring
	function automatic logic [SLOT_W-1:0] ring_add(input logic [SLOT_W-1:0] base,
			input logic [COUNT_W-1:0] off);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(base) + SUM_W'(off);
		if (sum >= SUM_W'(TABLE_ENTRIES))
			sum = sum - SUM_W'(TABLE_ENTRIES);
		return SLOT_W'(sum);
	endfunction

endpackage

// File: hw/rtl/psed_ram.sv
module psed_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [AW-1:0]            wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [AW-1:0]            rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
		if (rd_en)
			rd_data <= mem_q[rd_addr];
	end
endmodule

// File: hw/rtl/probe_ssid_extract_dedup.sv
// Probe-request SSID extractor with a deduplicating ring table. Frame bytes enter one word at
// a time (opcode frame); a byte that is not the last of its frame gives no result. At the last
// byte a management frame of at least 26 bytes starting 0x40 is counted as a probe request,
// its first SSID element is checked, and a clean SSID is looked up in a ring of TABLE_ENTRIES
// entries held in two RAMs with registered reads (SSID bytes, and length/time/hits). A lookup
// visits the held entries from the oldest: it reads an entry's length and skips the entry if
// the length differs, else compares its bytes one at a time until one differs or all match.
// A full match refreshes the entry's time and hit count; if none matches, a new entry is
// written and its bytes are copied into the byte RAM. Lookups and reads share the byte RAM's
// single read port. While a lookup or a read runs, or a finished result waits for the output
// register to free, the block takes no word; one result may wait in the output register while
// the next item is worked on. The capture bit (capture_q) is sampled at the last byte.
module probe_ssid_extract_dedup
	import psed_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_wr_en,
	input  logic      cfg_wr_data,
	input  logic      req_valid,
	output logic      req_ready,
	input  req_word_t req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rsp_word_t rsp
);
	localparam int SSID_AW = SLOT_W + OFF_W;

	state_t state_q, state_d;

	// configuration and table bookkeeping
	logic               capture_q;
	logic [SLOT_W-1:0]  head_q;
	logic [COUNT_W-1:0] count_q;
	logic [31:0]        probe_q, unique_q;

	// frame parser
	parse_state_t       ps_q, ps_d;
	logic [POS_W-1:0]   pos_q;
	logic [7:0]         rem_q, rem_d;
	logic [LEN_W-1:0]   clen_q, clen_d;
	logic               hdr_q, hdr_d, is_ssid_q, is_ssid_d, bad_q, bad_d;
	logic               over_q, over_d, empty_q, empty_d;
	logic [7:0]         cand_q [SSID_MAX_BYTES];
	logic               cand_we;
	logic [OFF_W-1:0]   cand_idx;

	// lookup sequencer
	logic [COUNT_W-1:0] i_q;
	logic [OFF_W-1:0]   j_q;
	logic [SLOT_W-1:0]  phys_q;
	logic [LEN_W-1:0]   slen_q;
	logic [31:0]        ts_q, hits_q;
	logic [OFF_W-1:0]   roff_q;

	// pending result
	logic [2:0]         res_outcome_q;
	logic [SLOT_W-1:0]  res_slot_q;
	logic [31:0]        res_hits_q, res_time_q;
	logic [7:0]         res_byte_q;
	logic [LEN_W-1:0]   res_len_q;

	// RAM ports
	logic               s_we, s_re, m_we, m_re;
	logic [SSID_AW-1:0] s_waddr, s_raddr;
	logic [7:0]         s_wdata, s_rdata;
	logic [SLOT_W-1:0]  m_waddr, m_raddr;
	meta_t              m_wdata, m_rdata;

	logic accept, out_free, is_frame, is_last, is_probe, rd_hit, do_search;
	logic len_eq, byte_eq, last_j, entries_done;
	logic [2:0]         end_outcome;
	logic [SLOT_W-1:0]  rd_phys, scan_phys, ins_idx;
	logic [31:0]        hits_next;

	psed_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES * SSID_MAX_BYTES)) u_ssid_ram (
		.clk    (clk),
		.wr_en  (s_we),
		.wr_addr(s_waddr),
		.wr_data(s_wdata),
		.rd_en  (s_re),
		.rd_addr(s_raddr),
		.rd_data(s_rdata)
	);

	psed_ram #(.WIDTH($bits(meta_t)), .DEPTH(TABLE_ENTRIES)) u_meta_ram (
		.clk    (clk),
		.wr_en  (m_we),
		.wr_addr(m_waddr),
		.wr_data(m_wdata),
		.rd_en  (m_re),
		.rd_addr(m_raddr),
		.rd_data(m_rdata)
	);

	assign out_free = !rsp_valid || rsp_ready;
	assign accept   = req_valid && req_ready;
	assign is_frame = req.opcode == OP_FRAME;
	assign is_last  = req.frame_last;

	// Parse one frame byte: work out the element walker's next state.
	always_comb begin
		ps_d      = ps_q;
		rem_d     = rem_q;
		clen_d    = clen_q;
		hdr_d     = hdr_q;
		is_ssid_d = is_ssid_q;
		bad_d     = bad_q;
		over_d    = over_q;
		empty_d   = empty_q;
		cand_we   = 1'b0;
		cand_idx  = OFF_W'(clen_q - LEN_W'(rem_q));
		if (pos_q == '0 && req.data_byte == PROBE_SUBTYPE)
			hdr_d = 1'b1;
		if (pos_q >= TAG_START) begin
			case (ps_q)
				PS_NUM: begin
					is_ssid_d = req.data_byte == 8'd0;
					ps_d      = PS_LEN;
				end
				PS_LEN: begin
					if (is_ssid_q) begin
						if (req.data_byte == 8'd0) begin
							empty_d = 1'b1;
							ps_d    = PS_DONE;
						end else if (req.data_byte > 8'(SSID_MAX_BYTES)) begin
							over_d = 1'b1;
							rem_d  = req.data_byte;
							ps_d   = PS_SKIP;
						end else begin
							clen_d = LEN_W'(req.data_byte);
							rem_d  = req.data_byte;
							ps_d   = PS_COLLECT;
						end
					end else if (req.data_byte == 8'd0) begin
						ps_d = PS_NUM;
					end else begin
						rem_d = req.data_byte;
						ps_d  = PS_SKIP;
					end
				end
				PS_SKIP: begin
					rem_d = rem_q - 8'd1;
					if (rem_d == 8'd0)
						ps_d = over_q ? PS_DONE : PS_NUM;
				end
				PS_COLLECT: begin
					cand_we = 1'b1;
					if (req.data_byte < PRINT_LOW || req.data_byte > PRINT_HIGH)
						bad_d = 1'b1;
					rem_d = rem_q - 8'd1;
					if (rem_d == 8'd0)
						ps_d = PS_DONE;
				end
				default: ;
			endcase
		end
	end

	// Decide the frame's fate at its last byte.
	always_comb begin
		is_probe = capture_q && req.frame_is_mgmt && pos_q >= MIN_LAST_POS && hdr_d;
		if (!is_probe)
			end_outcome = OC_IGNORED;
		else if (ps_d != PS_DONE)
			end_outcome = OC_NO_SSID;
		else if (empty_d || over_d)
			end_outcome = OC_BAD_LEN;
		else if (bad_d)
			end_outcome = OC_UNPRINT;
		else
			end_outcome = OC_NEW;
		do_search = end_outcome == OC_NEW;
	end

	assign rd_hit       = req.read_slot < count_q;
	assign rd_phys      = ring_add(head_q, COUNT_W'(req.read_slot));
	assign scan_phys    = ring_add(head_q, i_q);
	assign entries_done = i_q == count_q;
	assign len_eq       = m_rdata.len == slen_q;
	assign byte_eq      = s_rdata == cand_q[j_q];
	assign last_j       = LEN_W'(j_q) == slen_q - LEN_W'(1);
	assign hits_next    = (hits_q == '1) ? hits_q : hits_q + 32'd1;
	assign ins_idx      = (count_q < COUNT_W'(TABLE_ENTRIES)) ? scan_phys : head_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (!is_frame)
						state_d = rd_hit ? ST_RD : ST_OUT;
					else if (is_last)
						state_d = do_search ? ST_META : ST_OUT;
				end
			end
			ST_RD:   state_d = ST_OUT;
			ST_META: state_d = entries_done ? ST_INS : ST_LEN;
			ST_LEN:  state_d = len_eq ? ST_CMP : ST_META;
			ST_CMP: begin
				if (!byte_eq)
					state_d = ST_META;
				else if (last_j)
					state_d = ST_HIT;
			end
			ST_HIT:  state_d = ST_OUT;
			ST_INS:  state_d = ST_COPY;
			ST_COPY: state_d = last_j ? ST_OUT : ST_COPY;
			ST_OUT:  state_d = out_free ? ST_IDLE : ST_OUT;
			default: state_d = ST_IDLE;
		endcase
	end

	// handshake and RAM controls
	always_comb begin
		req_ready = 1'b0;
		s_we      = 1'b0;
		s_waddr   = {phys_q, j_q};
		s_wdata   = cand_q[j_q];
		s_re      = 1'b0;
		s_raddr   = {rd_phys, req.read_offset};
		m_we      = 1'b0;
		m_waddr   = phys_q;
		m_wdata   = '{len: slen_q, stamp: ts_q, hits: hits_next};
		m_re      = 1'b0;
		m_raddr   = rd_phys;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				s_re      = req_valid && !is_frame;
				m_re      = req_valid && !is_frame;
			end
			ST_META: begin
				m_re    = 1'b1;
				m_raddr = scan_phys;
			end
			ST_LEN: begin
				s_re    = 1'b1;
				s_raddr = {phys_q, OFF_W'(0)};
			end
			ST_CMP: begin
				s_re    = 1'b1;
				s_raddr = {phys_q, j_q + OFF_W'(1)};
			end
			ST_HIT: m_we = 1'b1;
			ST_INS: begin
				m_we    = 1'b1;
				m_waddr = ins_idx;
				m_wdata = '{len: slen_q, stamp: ts_q, hits: 32'd1};
			end
			ST_COPY: s_we = 1'b1;
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			capture_q <= 1'b0;
			head_q    <= '0;
			count_q   <= '0;
			probe_q   <= '0;
			unique_q  <= '0;
			ps_q      <= PS_NUM;
			pos_q     <= '0;
			rem_q     <= '0;
			clen_q    <= '0;
			hdr_q     <= 1'b0;
			is_ssid_q <= 1'b0;
			bad_q     <= 1'b0;
			over_q    <= 1'b0;
			empty_q   <= 1'b0;
			rsp_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en)
				capture_q <= cfg_wr_data;
			if (state_q == ST_IDLE && accept && is_frame) begin
				if (is_last) begin
					// drop the frame context, ready for the next frame
					ps_q      <= PS_NUM;
					pos_q     <= '0;
					rem_q     <= '0;
					clen_q    <= '0;
					hdr_q     <= 1'b0;
					is_ssid_q <= 1'b0;
					bad_q     <= 1'b0;
					over_q    <= 1'b0;
					empty_q   <= 1'b0;
					if (is_probe)
						probe_q <= probe_q + 32'd1;
				end else begin
					ps_q      <= ps_d;
					rem_q     <= rem_d;
					clen_q    <= clen_d;
					hdr_q     <= hdr_d;
					is_ssid_q <= is_ssid_d;
					bad_q     <= bad_d;
					over_q    <= over_d;
					empty_q   <= empty_d;
					if (pos_q != '1)
						pos_q <= pos_q + POS_W'(1);
				end
			end
			if (state_q == ST_INS) begin
				unique_q <= unique_q + 32'd1;
				if (count_q < COUNT_W'(TABLE_ENTRIES))
					count_q <= count_q + COUNT_W'(1);
				else
					head_q <= ring_add(head_q, COUNT_W'(1));
			end
			if (state_q == ST_OUT && out_free)
				rsp_valid <= 1'b1;
			else if (rsp_ready)
				rsp_valid <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept && is_frame && cand_we)
			cand_q[cand_idx] <= req.data_byte;
		case (state_q)
			ST_IDLE: begin
				res_outcome_q <= is_frame ? end_outcome : OC_IGNORED;
				res_slot_q    <= '0;
				res_hits_q    <= '0;
				res_time_q    <= '0;
				res_byte_q    <= '0;
				res_len_q     <= '0;
				roff_q        <= OFF_W'(req.read_offset);
				phys_q        <= rd_phys;
				slen_q        <= clen_d;
				ts_q          <= req.time_stamp;
				i_q           <= '0;
			end
			ST_RD: begin
				res_slot_q <= phys_q;
				res_hits_q <= m_rdata.hits;
				res_time_q <= m_rdata.stamp;
				res_len_q  <= m_rdata.len;
				res_byte_q <= (LEN_W'(roff_q) < m_rdata.len) ? s_rdata : 8'd0;
			end
			ST_META: phys_q <= scan_phys;
			ST_LEN: begin
				hits_q <= m_rdata.hits;
				j_q    <= '0;
				if (!len_eq)
					i_q <= i_q + COUNT_W'(1);
			end
			ST_CMP: begin
				if (!byte_eq)
					i_q <= i_q + COUNT_W'(1);
				else
					j_q <= j_q + OFF_W'(1);
			end
			ST_HIT: begin
				res_outcome_q <= OC_DUPLICATE;
				res_slot_q    <= phys_q;
				res_hits_q    <= hits_next;
			end
			ST_INS: begin
				phys_q <= ins_idx;
				j_q    <= '0;
			end
			ST_COPY: begin
				j_q           <= j_q + OFF_W'(1);
				res_outcome_q <= OC_NEW;
				res_slot_q    <= phys_q;
				res_hits_q    <= 32'd1;
			end
			default: ;
		endcase
		// hold the result word until it is taken
		if (state_q == ST_OUT && out_free) begin
			rsp.outcome      <= res_outcome_q;
			rsp.entry_slot   <= 4'(res_slot_q);
			rsp.entry_hits   <= res_hits_q;
			rsp.probe_total  <= probe_q;
			rsp.unique_total <= unique_q;
			rsp.table_count  <= 5'(count_q);
			rsp.read_byte    <= res_byte_q;
			rsp.read_length  <= 6'(res_len_q);
			rsp.read_time    <= res_time_q;
		end
	end
endmodule

// File: sim/probe_ssid_extract_dedup_tb.sv
// Probe-request SSID extractor: self-checking bench.
// Words go in through a valid/ready sender task. Each accepted word is run through a local
// copy of the frame walker and the SSID ring table, and any response it should cause is
// queued. A monitor compares each response word, field by field, with the oldest queued one.
module probe_ssid_extract_dedup_tb;
	import psed_pkg::*;

	logic      clk;
	logic      arst_n;
	logic      cfg_wr_en;
	logic      cfg_wr_data;
	logic      req_valid;
	logic      req_ready;
	req_word_t req;
	logic      rsp_valid;
	logic      rsp_ready;
	rsp_word_t rsp;

	probe_ssid_extract_dedup uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp)
	);

	localparam int QUIET_LIMIT = 20000;   // cycles with no word moving on either side
	localparam int LONG_HOLD   = 400;
	localparam int POOL_SIZE   = 24;      // more names than slots, so the ring wraps
	localparam int REQ_W       = $bits(req_word_t);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// ---------------------------------------------------------------------------------
	// Shadow of the block: ring table, counters, frame walker state, capture register
	// ---------------------------------------------------------------------------------
	logic [7:0]   tab_ssid [TABLE_ENTRIES][SSID_MAX_BYTES];
	int           tab_len  [TABLE_ENTRIES];
	logic [31:0]  tab_time [TABLE_ENTRIES];
	logic [31:0]  tab_hits [TABLE_ENTRIES];
	int           tab_head, tab_count;
	logic [31:0]  probes_seen, uniques_seen;
	int           byte_pos, remain, cand_len;
	parse_state_t walk_state;
	logic [7:0]   cand [SSID_MAX_BYTES];
	bit           f_hdr, f_ssid, f_bad, f_over, f_empty;
	bit           capture;

	rsp_word_t    pending_rsp [$];
	bit           failed;

	// Work out the response to one word and advance the shadow state. Returns 1 when the
	// word causes a response (every read, and the last byte of a frame).
	function automatic bit ssid_outcome(input req_word_t w, output rsp_word_t r);
		int  p, s, i, k;
		bit  found;
		r = '0;
		if (w.opcode == OP_READ) begin
			if (int'(w.read_slot) < tab_count) begin
				s = (tab_head + int'(w.read_slot)) % TABLE_ENTRIES;
				r.entry_slot  = 4'(s);
				r.read_length = 6'(tab_len[s]);
				r.read_time   = tab_time[s];
				r.entry_hits  = tab_hits[s];
				if (int'(w.read_offset) < tab_len[s])
					r.read_byte = tab_ssid[s][w.read_offset];
			end
		end else begin
			p = byte_pos;
			if (p == 0 && w.data_byte == PROBE_SUBTYPE)
				f_hdr = 1'b1;
			// walk the tagged elements from the start of the body
			if (p >= 24) begin
				case (walk_state)
				PS_NUM: begin
					f_ssid = (w.data_byte == 8'd0);
					walk_state = PS_LEN;
				end
				PS_LEN: begin
					if (f_ssid) begin
						if (w.data_byte == 8'd0) begin
							f_empty = 1'b1;
							walk_state = PS_DONE;
						end else if (int'(w.data_byte) > SSID_MAX_BYTES) begin
							f_over = 1'b1;
							remain = int'(w.data_byte);
							walk_state = PS_SKIP;
						end else begin
							cand_len = int'(w.data_byte);
							remain = int'(w.data_byte);
							walk_state = PS_COLLECT;
						end
					end else if (w.data_byte == 8'd0) begin
						walk_state = PS_NUM;
					end else begin
						remain = int'(w.data_byte);
						walk_state = PS_SKIP;
					end
				end
				PS_SKIP: begin
					remain--;
					if (remain == 0)
						walk_state = f_over ? PS_DONE : PS_NUM;
				end
				PS_COLLECT: begin
					cand[cand_len - remain] = w.data_byte;
					if (w.data_byte < PRINT_LOW || w.data_byte > PRINT_HIGH)
						f_bad = 1'b1;
					remain--;
					if (remain == 0)
						walk_state = PS_DONE;
				end
				default: ;
				endcase
			end
			if (byte_pos < 65535)
				byte_pos++;
			if (!w.frame_last)
				return 1'b0;
			if (capture && w.frame_is_mgmt && p + 1 >= 26 && f_hdr) begin
				probes_seen++;
				if (walk_state != PS_DONE)
					r.outcome = OC_NO_SSID;
				else if (f_empty || f_over)
					r.outcome = OC_BAD_LEN;
				else if (f_bad)
					r.outcome = OC_UNPRINT;
				else begin
					// look up from the oldest entry; refresh on a match
					found = 1'b0;
					for (i = 0; i < tab_count && !found; i++) begin
						s = (tab_head + i) % TABLE_ENTRIES;
						if (tab_len[s] == cand_len) begin
							found = 1'b1;
							for (k = 0; k < cand_len; k++)
								if (tab_ssid[s][k] != cand[k])
									found = 1'b0;
							if (found) begin
								tab_time[s] = w.time_stamp;
								if (tab_hits[s] != 32'hFFFF_FFFF)
									tab_hits[s]++;
								r.outcome    = OC_DUPLICATE;
								r.entry_slot = 4'(s);
								r.entry_hits = tab_hits[s];
							end
						end
					end
					if (!found) begin
						// append, or overwrite the oldest once full
						if (tab_count < TABLE_ENTRIES) begin
							s = (tab_head + tab_count) % TABLE_ENTRIES;
							tab_count++;
						end else begin
							s = tab_head;
							tab_head = (tab_head + 1) % TABLE_ENTRIES;
						end
						for (k = 0; k < SSID_MAX_BYTES; k++)
							tab_ssid[s][k] = (k < cand_len) ? cand[k] : 8'd0;
						tab_len[s]  = cand_len;
						tab_time[s] = w.time_stamp;
						tab_hits[s] = 32'd1;
						uniques_seen++;
						r.outcome    = OC_NEW;
						r.entry_slot = 4'(s);
						r.entry_hits = 32'd1;
					end
				end
			end
			byte_pos = 0;
			walk_state = PS_NUM;
			remain = 0;
			cand_len = 0;
			{f_hdr, f_ssid, f_bad, f_over, f_empty} = '0;
		end
		r.probe_total  = probes_seen;
		r.unique_total = uniques_seen;
		r.table_count  = 5'(tab_count);
		return 1'b1;
	endfunction

	// ---------------------------------------------------------------------------------
	// Sender
	// ---------------------------------------------------------------------------------
	int snd_idle, rcv_idle;
	int words_sent;
	logic [7:0] frame_q [$];
	logic [7:0] pool_ssid [POOL_SIZE][SSID_MAX_BYTES];
	int         pool_len  [POOL_SIZE];

	// Offer one word, hold it until taken, then queue its expected response. With
	// force_oc the outcome is the one typed into the directed table.
	task automatic put_word(input req_word_t w, input bit force_oc, input outcome_t oc);
		rsp_word_t r;
		while ($urandom_range(99) < snd_idle) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req       <= w;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		words_sent++;
		if (ssid_outcome(w, r)) begin
			if (force_oc)
				r.outcome = oc;
			pending_rsp = {pending_rsp, r};
		end
	endtask

	function automatic req_word_t read_word(input int slot, input int offs);
		req_word_t w;
		w = REQ_W'({$urandom, $urandom});
		w.opcode      = OP_READ;
		w.read_slot   = 4'(slot);
		w.read_offset = 5'(offs);
		return w;
	endfunction

	// bias reads mostly towards held slots, sometimes beyond the count
	function automatic req_word_t random_read();
		int slot;
		if ($urandom_range(3) == 0 || tab_count == 0)
			slot = $urandom_range(TABLE_ENTRIES - 1);
		else
			slot = $urandom_range(tab_count - 1);
		return read_word(slot, $urandom_range(SSID_MAX_BYTES - 1));
	endfunction

	// Send frame_q as one frame; read_at >= 0 slips a read in before that byte
	task automatic send_frame(input bit mgmt, input bit force_oc, input outcome_t oc,
			input int read_at);
		req_word_t w;
		int i;
		for (i = 0; i < frame_q.size(); i++) begin
			if (i == read_at)
				put_word(random_read(), 1'b0, OC_IGNORED);
			w = REQ_W'({$urandom, $urandom});
			w.opcode        = OP_FRAME;
			w.data_byte     = frame_q[i];
			w.frame_last    = (i == frame_q.size() - 1);
			w.frame_is_mgmt = mgmt;
			put_word(w, force_oc && w.frame_last, oc);
		end
	endtask

	// Hold the sender off until every queued response has been taken
	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_rsp.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_capture(input bit v);
		drain();
		repeat (20) @(posedge clk);    // let the block settle before the capture bit changes
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		capture = v;
	endtask

	function automatic logic [7:0] printable();
		return 8'($urandom_range(PRINT_HIGH, PRINT_LOW));
	endfunction

	// 24 header bytes, first one given
	task automatic start_frame(input logic [7:0] hdr);
		frame_q = {hdr};
		repeat (23) frame_q = {frame_q, 8'($urandom)};
	endtask

	// ---------------------------------------------------------------------------------
	// Directed table
	// ---------------------------------------------------------------------------------
	typedef struct {
		logic [7:0] hdr;
		bit         mgmt;
		int         pre;     // 0 none, 1 other element, 2 empty other element, 3 runaway element
		int         tag;
		int         elen;    // length byte of the element
		int         nbytes;  // element bytes actually present
		int         fill;    // 0 = random printable
		int         pad;
		int         cut;     // >0 trims the frame to this length
		bit         mid_read;
		bit         rd;
		int         rslot;
		int         roff;
		bit         known;
		outcome_t   oc;
	} probe_case_t;

	probe_case_t cases [] = '{
		'{8'h40, 1, 0, 0,  4,  4,   0,   0,  0, 0, 0, 0,  0, 1, OC_IGNORED},   // capture off
		'{8'h40, 0, 0, 0,  4,  4,   0,   0,  0, 0, 0, 0,  0, 1, OC_IGNORED},   // not management
		'{8'h50, 1, 0, 0,  4,  4,   0,   0,  0, 0, 0, 0,  0, 1, OC_IGNORED},   // other subtype
		'{8'h40, 1, 0, 5,  0,  0,   0,   0, 25, 0, 0, 0,  0, 1, OC_IGNORED},   // one byte short
		'{8'h40, 1, 0, 5,  0,  0,   0,   0,  0, 0, 0, 0,  0, 1, OC_NO_SSID},   // shortest, no SSID
		'{8'h40, 1, 0, 0,  0,  0,   0,   0,  0, 0, 0, 0,  0, 1, OC_BAD_LEN},   // empty SSID
		'{8'h40, 1, 0, 0, 33, 33,  97,   0,  0, 0, 0, 0,  0, 1, OC_BAD_LEN},   // oversize, whole
		'{8'h40, 1, 0, 0, 40, 10,  97,   0,  0, 0, 0, 0,  0, 1, OC_NO_SSID},   // oversize, cut
		'{8'h40, 1, 0, 0,  5,  3,   0,   0,  0, 0, 0, 0,  0, 1, OC_NO_SSID},   // SSID cut short
		'{8'h40, 1, 0, 0,  4,  4,  31,   0,  0, 0, 0, 0,  0, 1, OC_UNPRINT},
		'{8'h40, 1, 0, 0,  4,  4, 127,   0,  0, 0, 0, 0,  0, 1, OC_UNPRINT},
		'{8'h40, 1, 0, 0,  1,  1,  32,   0,  0, 0, 0, 0,  0, 1, OC_NEW},
		'{8'h40, 1, 0, 0,  1,  1,  32,   0,  0, 0, 0, 0,  0, 1, OC_DUPLICATE},
		'{8'h40, 1, 0, 0, 32, 32, 126,   0,  0, 0, 0, 0,  0, 1, OC_NEW},       // longest SSID
		'{8'h40, 1, 1, 0,  6,  6,   0,   0,  0, 0, 0, 0,  0, 0, OC_IGNORED},
		'{8'h40, 1, 3, 0,  0,  0,   0,   0,  0, 0, 0, 0,  0, 1, OC_NO_SSID},   // runaway element
		'{8'h40, 1, 2, 0,  3,  3,   0,   2,  0, 0, 0, 0,  0, 0, OC_IGNORED},
		'{8'h40, 1, 0, 0,  0,  0,   0,   0,  0, 0, 1, 0,  0, 0, OC_IGNORED},   // read oldest
		'{8'h40, 1, 0, 0,  0,  0,   0,   0,  0, 0, 1, 1, 31, 0, OC_IGNORED},
		'{8'h40, 1, 0, 0,  0,  0,   0,   0,  0, 0, 1, 15, 0, 0, OC_IGNORED},   // beyond count
		'{8'h40, 1, 0, 0,  8,  8,   0,   0,  0, 1, 0, 0,  0, 0, OC_IGNORED},   // read mid-frame
		'{8'h40, 1, 0, 0,  7,  7,   0,  40,  0, 0, 0, 0,  0, 0, OC_IGNORED},   // long frame
		'{8'hFF, 1, 0, 0,  4,  4,   0,   0,  0, 0, 0, 0,  0, 1, OC_IGNORED}
	};

	task automatic run_directed();
		probe_case_t c;
		int i, k;
		for (i = 0; i < cases.size(); i++) begin
			c = cases[i];
			if (i == 1)
				set_capture(1'b1);
			if (c.rd) begin
				put_word(read_word(c.rslot, c.roff), 1'b0, OC_IGNORED);
			end else begin
				start_frame(c.hdr);
				case (c.pre)
				1: frame_q = {frame_q, 8'd3, 8'd2, 8'($urandom), 8'($urandom)};
				2: frame_q = {frame_q, 8'd221, 8'd0};
				3: frame_q = {frame_q, 8'd7, 8'd50, 8'($urandom), 8'($urandom)};
				default: ;
				endcase
				if (c.pre != 3) begin
					frame_q = {frame_q, 8'(c.tag), 8'(c.elen)};
					for (k = 0; k < c.nbytes; k++)
						frame_q = {frame_q, (c.fill != 0) ? 8'(c.fill) : printable()};
				end
				repeat (c.pad) frame_q = {frame_q, 8'($urandom)};
				while (c.cut > 0 && frame_q.size() > c.cut)
					void'(frame_q.pop_back());
				send_frame(c.mgmt, c.known, c.oc, c.mid_read ? 25 : -1);
			end
		end
	endtask

	// ---------------------------------------------------------------------------------
	// Random frames: mostly well-formed probes drawn from a small pool of names
	// ---------------------------------------------------------------------------------
	task automatic run_random(input int n_words);
		int stop_at, kind, n, k, len, pick, bad_at;
		bit mgmt;
		stop_at = words_sent + n_words;
		while (words_sent < stop_at) begin
			kind = $urandom_range(99);
			mgmt = ($urandom_range(19) != 0);
			if (kind >= 95) begin
				// noise: any length, any bytes, any class
				frame_q = {};
				n = $urandom_range(40, 1);
				repeat (n) frame_q = {frame_q, 8'($urandom)};
				mgmt = 1'($urandom_range(1));
			end else begin
				start_frame(($urandom_range(15) == 0) ? 8'($urandom) : PROBE_SUBTYPE);
				repeat ($urandom_range(2)) begin
					len = $urandom_range(6);
					frame_q = {frame_q, 8'($urandom_range(255, 1)), 8'(len)};
					repeat (len) frame_q = {frame_q, 8'($urandom)};
				end
				pick = $urandom_range(POOL_SIZE - 1);
				len = pool_len[pick];
				frame_q = {frame_q, 8'd0};
				if (kind >= 80 && kind < 88) begin
					// empty or oversize SSID, whole or cut
					len = ($urandom_range(3) == 0) ? 0 : $urandom_range(255, 33);
					frame_q = {frame_q, 8'(len)};
					repeat ((len > 40) ? $urandom_range(40) : len)
						frame_q = {frame_q, printable()};
				end else begin
					frame_q = {frame_q, 8'(len)};
					bad_at = (kind >= 70 && kind < 80) ? $urandom_range(len - 1) : -1;
					for (k = 0; k < len; k++) begin
						if (k == bad_at)
							frame_q = {frame_q, ($urandom_range(1) != 0) ?
								8'($urandom_range(31)) : 8'($urandom_range(255, 127))};
						else
							frame_q = {frame_q, pool_ssid[pick][k]};
					end
				end
				repeat ($urandom_range(3)) frame_q = {frame_q, 8'($urandom)};
				if (kind >= 88)
					frame_q = frame_q[0:$urandom_range(frame_q.size() - 1)];
			end
			send_frame(mgmt, 1'b0, OC_IGNORED,
				($urandom_range(19) == 0) ? $urandom_range(frame_q.size() - 1) : -1);
			if ($urandom_range(3) == 0)
				repeat ($urandom_range(3, 1)) put_word(random_read(), 1'b0, OC_IGNORED);
		end
	endtask

	// ---------------------------------------------------------------------------------
	// Receiver: random stalls plus one long hold-off counted here
	// ---------------------------------------------------------------------------------
	int hold_asks, hold_done;
	int hold_left;

	always @(posedge clk) begin
		if (hold_asks != hold_done) begin
			hold_left = LONG_HOLD;
			hold_done = hold_asks;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(99) >= rcv_idle);
		end
	end

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			failed = 1'b1;
		end
	endfunction

	always @(posedge clk) begin
		rsp_word_t e;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_rsp.size() == 0) begin
				$error("response word with nothing expected: 0x%0h", rsp);
				failed = 1'b1;
			end else begin
				e = pending_rsp.pop_front();
				check_field("outcome",      32'(e.outcome),      32'(rsp.outcome));
				check_field("entry_slot",   32'(e.entry_slot),   32'(rsp.entry_slot));
				check_field("entry_hits",   e.entry_hits,        rsp.entry_hits);
				check_field("probe_total",  e.probe_total,       rsp.probe_total);
				check_field("unique_total", e.unique_total,      rsp.unique_total);
				check_field("table_count",  32'(e.table_count),  32'(rsp.table_count));
				check_field("read_byte",    32'(e.read_byte),    32'(rsp.read_byte));
				check_field("read_length",  32'(e.read_length),  32'(rsp.read_length));
				check_field("read_time",    e.read_time,         rsp.read_time);
			end
		end
	end

	// Watchdog: too long with no word moving either way
	int quiet;
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		int i, k;
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = 1'b0;
		req_valid   = 1'b0;
		req         = '0;
		rsp_ready   = 1'b0;
		snd_idle    = 0;
		rcv_idle    = 0;
		hold_asks   = 0;
		capture     = 1'b0;
		tab_head    = 0;
		tab_count   = 0;
		probes_seen = '0;
		uniques_seen = '0;
		byte_pos    = 0;
		remain      = 0;
		cand_len    = 0;
		walk_state  = PS_NUM;
		{f_hdr, f_ssid, f_bad, f_over, f_empty} = '0;
		// name pool: the extremes of length always present
		for (i = 0; i < POOL_SIZE; i++) begin
			pool_len[i] = (i == 0) ? 1 : (i == 1) ? SSID_MAX_BYTES :
				$urandom_range(SSID_MAX_BYTES, 1);
			for (k = 0; k < SSID_MAX_BYTES; k++)
				pool_ssid[i][k] = printable();
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();

		// sender sparse-ish, receiver sluggish; start with a long hold-off to back up the block
		snd_idle  = 30;
		rcv_idle  = 49;
		hold_asks++;
		run_random(360);
		set_capture(1'b0);
		run_random(40);
		set_capture(1'b1);

		snd_idle = 49;
		rcv_idle = 30;
		run_random(360);
		drain();

		snd_idle = 0;
		rcv_idle = 0;
		run_random(340);

		drain();
		repeat (50) @(posedge clk);
		if (!failed && pending_rsp.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
